>>> design/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types, constants and the nibble decode for the int4 similarity
// accumulator.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int ITEM_BYTES   = 8;
  localparam int NIBBLES      = 2 * ITEM_BYTES;
  localparam int WORD_W       = 8 * ITEM_BYTES;
  localparam int COUNT_W      = 4;
  localparam int NIBBLE_W     = 4;
  localparam int ELEM_W       = 5;
  localparam int ELEM_LIMIT   = 225;

  localparam int ITEM_DOT_W   = 13;
  localparam int ITEM_NORM_W  = 12;
  localparam int ITEM_DIST_W  = 14;

  localparam int DOT_OUT_W    = 26;
  localparam int NORM_OUT_W   = 25;

  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_NIBBLE_MASK  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGN_PATTERN = 2'd1;

  localparam logic [NIBBLE_W-1:0] NIBBLE_MASK_RESET  = 4'd15;
  localparam logic [NIBBLE_W-1:0] SIGN_PATTERN_RESET = 4'd8;

  typedef struct packed {
    logic [NIBBLE_W-1:0] nibble_mask;
    logic [NIBBLE_W-1:0] sign_pattern;
  } cfg_t;

  typedef struct packed {
    logic signed [ITEM_DOT_W-1:0] dot;
    logic [ITEM_NORM_W-1:0]       left_sq;
    logic [ITEM_NORM_W-1:0]       right_sq;
    logic [ITEM_DIST_W-1:0]       dist_sq;
  } item_sums_t;

  function automatic logic signed [ELEM_W-1:0] decode_nibble(
    input logic [NIBBLE_W-1:0] raw,
    input cfg_t                cfg
  );
    logic [NIBBLE_W-1:0] v;
    v = (raw & cfg.nibble_mask) ^ cfg.sign_pattern;
    return $signed({1'b0, v}) - $signed({1'b0, cfg.sign_pattern});
  endfunction

endpackage

>>> design/int4_vector_similarity_accumulator.sv
// ----------------------------------------------------------------------------
// int4_vector_similarity_accumulator
// Streams two packed int4 vectors and returns dot product, both squared
// norms and squared distance for each vector pair.
// ----------------------------------------------------------------------------
// One item of up to eight byte pairs is taken every cycle unless input ready is
// low. An item sits in the input register, where sixteen lanes are decoded,
// multiplied and reduced by an adder tree into the saturating accumulators;
// the item flagged last loads the result register when it leaves the input
// register, and the sums clear. Input ready drops only while a finished result
// is held unread and a further last item is waiting in the input register.
// Configuration writes take effect at once and are always accepted.
module int4_vector_similarity_accumulator #(
  parameter int MAX_VECTOR_BYTES = 65536,
  parameter int BYTES_PER_ITEM   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [isa_pkg::WORD_W-1:0]           left_bytes,
  input  logic [isa_pkg::WORD_W-1:0]           right_bytes,
  input  logic [isa_pkg::COUNT_W-1:0]          byte_count,
  input  logic                                 last_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [isa_pkg::DOT_OUT_W-1:0] dot_product,
  output logic [isa_pkg::NORM_OUT_W-1:0]       left_energy,
  output logic [isa_pkg::NORM_OUT_W-1:0]       right_energy,
  output logic [isa_pkg::NORM_OUT_W-1:0]       squared_distance,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [isa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [isa_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import isa_pkg::*;

  cfg_t               cfg;
  logic               s1_valid;
  logic               s1_last;
  logic [WORD_W-1:0]  s1_left;
  logic [WORD_W-1:0]  s1_right;
  logic [COUNT_W-1:0] s1_count;
  logic               s1_go;
  item_sums_t         sums;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nibble_mask  <= NIBBLE_MASK_RESET;
      cfg.sign_pattern <= SIGN_PATTERN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NIBBLE_MASK:  cfg.nibble_mask  <= cfg_data;
        REG_SIGN_PATTERN: cfg.sign_pattern <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_left  <= left_bytes;
      s1_right <= right_bytes;
      s1_count <= byte_count;
      s1_last  <= last_word;
    end
  end

  isa_item_sum #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_item_sum (
    .left_bytes (s1_left),
    .right_bytes(s1_right),
    .byte_count (s1_count),
    .cfg        (cfg),
    .sums       (sums)
  );

  isa_accum #(
    .MAX_VECTOR_BYTES(MAX_VECTOR_BYTES)
  ) u_accum (
    .clk             (clk),
    .rst             (rst),
    .take            (s1_go),
    .last            (s1_last),
    .sums            (sums),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .dot_product     (dot_product),
    .left_energy     (left_energy),
    .right_energy    (right_energy),
    .squared_distance(squared_distance)
  );

  a_last_loads_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> out_valid)
    else $error("last item did not load the result register");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_go && s1_last))
    else $error("result appeared without a last item");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_last) && $stable(s1_count)))
    else $error("stalled item in input register changed");

endmodule

>>> design/isa_item_sum.sv
// ----------------------------------------------------------------------------
// isa_item_sum
// Decodes the sixteen nibble lanes of one item and reduces the per-lane
// products and squares through a four-level adder tree.
// ----------------------------------------------------------------------------
module isa_item_sum #(
  parameter int BYTES_PER_ITEM = 8
) (
  input  logic [isa_pkg::WORD_W-1:0]  left_bytes,
  input  logic [isa_pkg::WORD_W-1:0]  right_bytes,
  input  logic [isa_pkg::COUNT_W-1:0] byte_count,
  input  isa_pkg::cfg_t               cfg,
  output isa_pkg::item_sums_t         sums
);
  import isa_pkg::*;

  localparam int LEVELS = $clog2(NIBBLES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(BYTES_PER_ITEM);

  logic [COUNT_W-1:0] count;

  assign count = (byte_count > COUNT_MAX) ? COUNT_MAX : byte_count;

  always_comb begin
    logic signed [ITEM_DOT_W-1:0] dot_node [NIBBLES];
    logic [ITEM_NORM_W-1:0]       lsq_node [NIBBLES];
    logic [ITEM_NORM_W-1:0]       rsq_node [NIBBLES];
    logic [ITEM_DIST_W-1:0]       dsq_node [NIBBLES];
    logic signed [ELEM_W-1:0]     l;
    logic signed [ELEM_W-1:0]     r;
    logic signed [ELEM_W:0]       d;
    logic signed [ITEM_DIST_W-1:0] lx;
    logic signed [ITEM_DIST_W-1:0] rx;
    logic signed [ITEM_DIST_W-1:0] dx;
    for (int n = 0; n < NIBBLES; n++) begin
      l = decode_nibble(left_bytes[n*NIBBLE_W +: NIBBLE_W], cfg);
      r = decode_nibble(right_bytes[n*NIBBLE_W +: NIBBLE_W], cfg);
      d = {l[ELEM_W-1], l} - {r[ELEM_W-1], r};
      lx = {{(ITEM_DIST_W-ELEM_W){l[ELEM_W-1]}}, l};
      rx = {{(ITEM_DIST_W-ELEM_W){r[ELEM_W-1]}}, r};
      dx = {{(ITEM_DIST_W-ELEM_W-1){d[ELEM_W]}}, d};
      if (COUNT_W'(n / 2) < count) begin
        dot_node[n] = ITEM_DOT_W'(lx * rx);
        lsq_node[n] = ITEM_NORM_W'(lx * lx);
        rsq_node[n] = ITEM_NORM_W'(rx * rx);
        dsq_node[n] = $unsigned(dx * dx);
      end else begin
        dot_node[n] = '0;
        lsq_node[n] = '0;
        rsq_node[n] = '0;
        dsq_node[n] = '0;
      end
    end
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      for (int k = 0; k < (NIBBLES >> (lvl + 1)); k++) begin
        dot_node[k] = dot_node[2*k] + dot_node[2*k+1];
        lsq_node[k] = lsq_node[2*k] + lsq_node[2*k+1];
        rsq_node[k] = rsq_node[2*k] + rsq_node[2*k+1];
        dsq_node[k] = dsq_node[2*k] + dsq_node[2*k+1];
      end
    end
    sums.dot      = dot_node[0];
    sums.left_sq  = lsq_node[0];
    sums.right_sq = rsq_node[0];
    sums.dist_sq  = dsq_node[0];
  end

endmodule

>>> design/isa_accum.sv
// ----------------------------------------------------------------------------
// isa_accum
// Saturating accumulators for the four sums and the result register that
// holds a finished vector pair until it is transferred.
// ----------------------------------------------------------------------------
module isa_accum #(
  parameter int MAX_VECTOR_BYTES = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic                                last,
  input  isa_pkg::item_sums_t                 sums,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [isa_pkg::DOT_OUT_W-1:0] dot_product,
  output logic [isa_pkg::NORM_OUT_W-1:0]      left_energy,
  output logic [isa_pkg::NORM_OUT_W-1:0]      right_energy,
  output logic [isa_pkg::NORM_OUT_W-1:0]      squared_distance
);
  import isa_pkg::*;

  localparam longint SUM_LIMIT = longint'(MAX_VECTOR_BYTES) * 2 * ELEM_LIMIT;
  localparam int NORM_ACC_W = $clog2(SUM_LIMIT + 1);
  localparam int DOT_ACC_W  = NORM_ACC_W + 1;
  localparam int DOT_SUM_W  = ((DOT_ACC_W > ITEM_DOT_W) ? DOT_ACC_W : ITEM_DOT_W) + 1;
  localparam int NORM_SUM_W = ((NORM_ACC_W > ITEM_DIST_W) ? NORM_ACC_W : ITEM_DIST_W) + 1;

  localparam logic signed [DOT_SUM_W-1:0] DOT_HI = DOT_SUM_W'(SUM_LIMIT);
  localparam logic signed [DOT_SUM_W-1:0] DOT_LO = -DOT_HI;
  localparam logic [NORM_SUM_W-1:0]       NORM_HI = NORM_SUM_W'(SUM_LIMIT);

  logic signed [DOT_ACC_W-1:0] dot_acc;
  logic [NORM_ACC_W-1:0]       left_acc;
  logic [NORM_ACC_W-1:0]       right_acc;
  logic [NORM_ACC_W-1:0]       dist_acc;

  logic signed [DOT_SUM_W-1:0] dot_sum;
  logic [NORM_SUM_W-1:0]       left_total;
  logic [NORM_SUM_W-1:0]       right_total;
  logic [NORM_SUM_W-1:0]       dist_sum;

  logic signed [DOT_ACC_W-1:0] dot_next;
  logic [NORM_ACC_W-1:0]       left_next;
  logic [NORM_ACC_W-1:0]       right_next;
  logic [NORM_ACC_W-1:0]       dist_next;

  assign dot_sum     = DOT_SUM_W'(dot_acc) + DOT_SUM_W'(sums.dot);
  assign left_total  = NORM_SUM_W'(left_acc) + NORM_SUM_W'(sums.left_sq);
  assign right_total = NORM_SUM_W'(right_acc) + NORM_SUM_W'(sums.right_sq);
  assign dist_sum    = NORM_SUM_W'(dist_acc) + NORM_SUM_W'(sums.dist_sq);

  always_comb begin
    if (dot_sum > DOT_HI) begin
      dot_next = DOT_ACC_W'(DOT_HI);
    end else if (dot_sum < DOT_LO) begin
      dot_next = DOT_ACC_W'(DOT_LO);
    end else begin
      dot_next = DOT_ACC_W'(dot_sum);
    end
    left_next  = (left_total > NORM_HI) ? NORM_ACC_W'(NORM_HI) : NORM_ACC_W'(left_total);
    right_next = (right_total > NORM_HI) ? NORM_ACC_W'(NORM_HI) : NORM_ACC_W'(right_total);
    dist_next  = (dist_sum > NORM_HI) ? NORM_ACC_W'(NORM_HI) : NORM_ACC_W'(dist_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc   <= '0;
      left_acc  <= '0;
      right_acc <= '0;
      dist_acc  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take && last) begin
        dot_acc   <= '0;
        left_acc  <= '0;
        right_acc <= '0;
        dist_acc  <= '0;
        out_valid <= 1'b1;
      end else begin
        if (take) begin
          dot_acc   <= dot_next;
          left_acc  <= left_next;
          right_acc <= right_next;
          dist_acc  <= dist_next;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      dot_product      <= DOT_OUT_W'(dot_next);
      left_energy      <= NORM_OUT_W'(left_next);
      right_energy     <= NORM_OUT_W'(right_next);
      squared_distance <= NORM_OUT_W'(dist_next);
    end
  end

endmodule
